### hdl/tld_pkg.sv
// Shared constants, types and helpers for the temperature digit writer.
package tld_pkg;

	localparam int RAW_W   = 16;
	localparam int DEC_W   = 3;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 8;
	localparam int BASE_W  = 24;
	localparam int ACC_W   = 36;
	localparam int REM_W   = 16;
	localparam int VALUE_W = 21;
	localparam int DIGIT_W = 4;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] REG_DECIMAL_PLACES = 3'd0;

	localparam logic [DEC_W-1:0] DEC_RESET = 3'd3;
	localparam logic [DEC_W-1:0] DEC_MAX   = 3'd4;

	localparam logic signed [BASE_W-1:0] OFFSET_NUM = 24'sd1242020;
	localparam logic [REM_W:0]           DENOM      = 17'd34000;

	localparam logic [ADDR_W-1:0] SCAN_LIMIT_REG = 4'hB;

	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] value;
	} tld_scale_res_t;

	function automatic longint pow10(input int e);
		longint p;
		p = 1;
		for (int k = 0; k < e; k++) begin
			p = p * 10;
		end
		return p;
	endfunction

endpackage

### hdl/tld_scale.sv
// Offset, decade scaling and bit-serial division by 34000 with saturation.
module tld_scale #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [tld_pkg::RAW_W-1:0]      raw,
	input  logic        [tld_pkg::DEC_W-1:0]      dec,
	output tld_pkg::tld_scale_res_t               res
);
	import tld_pkg::*;

	localparam logic [26:0] SAT_LIMIT = 27'(pow10(MAX_DIGITS) - 1);
	localparam int          CNT_W     = $clog2(ACC_W);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]             state_q;
	logic [ACC_W-1:0]       acc_q;
	logic [REM_W-1:0]       rem_q;
	logic [DEC_W-1:0]       mul_cnt_q;
	logic [CNT_W-1:0]       bit_cnt_q;
	logic signed [BASE_W-1:0] rawx;
	logic signed [BASE_W-1:0] base;
	logic [REM_W:0]         trial;
	logic                   ge;

	always_comb begin
		rawx  = BASE_W'(raw);
		base  = (rawx <<< 6) + (rawx <<< 5) + (rawx <<< 2) + OFFSET_NUM;
		trial = {rem_q, acc_q[ACC_W-1]};
		ge    = trial >= DENOM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_MUL;
				S_MUL:  if (mul_cnt_q == '0) state_q <= S_DIV;
				S_DIV:  if (bit_cnt_q == '0) state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc_q     <= base[BASE_W-1] ? '0 : ACC_W'(base[BASE_W-2:0]);
				mul_cnt_q <= dec;
			end
			S_MUL: begin
				rem_q     <= '0;
				bit_cnt_q <= CNT_W'(ACC_W - 1);
				if (mul_cnt_q != '0) begin
					acc_q     <= (acc_q << 3) + (acc_q << 1);
					mul_cnt_q <= mul_cnt_q - 3'd1;
				end
			end
			S_DIV: begin
				rem_q     <= ge ? REM_W'(trial - DENOM) : trial[REM_W-1:0];
				acc_q     <= {acc_q[ACC_W-2:0], ge};
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.done  = state_q == S_DONE;
		res.value = (27'(acc_q[VALUE_W-1:0]) > SAT_LIMIT) ? VALUE_W'(SAT_LIMIT)
			: acc_q[VALUE_W-1:0];
	end

endmodule

### hdl/tld_bcd.sv
// Bit-serial binary to BCD conversion (shift and add three).
module tld_bcd #(
	parameter int NDIG = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tld_pkg::VALUE_W-1:0]  value,
	output logic                         done,
	output logic [NDIG*4-1:0]            bcd
);
	import tld_pkg::*;

	localparam int CNT_W = $clog2(VALUE_W);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [VALUE_W-1:0]  sh_q;
	logic [NDIG*4-1:0]   bcd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NDIG*4-1:0]   adj;

	always_comb begin
		for (int k = 0; k < NDIG; k++) begin
			adj[k*DIGIT_W +: DIGIT_W] = (bcd_q[k*DIGIT_W +: DIGIT_W] >= 4'd5)
				? bcd_q[k*DIGIT_W +: DIGIT_W] + 4'd3 : bcd_q[k*DIGIT_W +: DIGIT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_RUN;
				S_RUN:  if (cnt_q == '0) state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sh_q  <= value;
				bcd_q <= '0;
				cnt_q <= CNT_W'(VALUE_W - 1);
			end
			S_RUN: begin
				bcd_q <= {adj[NDIG*4-2:0], sh_q[VALUE_W-1]};
				sh_q  <= sh_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign done = state_q == S_DONE;
	assign bcd  = bcd_q;

endmodule

### hdl/temp_to_led_digit_writes.sv
// Top level: temperature sample in, display register writes out.
//
// sample channel: raw_sample with sample_valid/sample_stall. One sample is
// processed at a time; sample_stall stays high from acceptance until the
// last write of that sample has been taken.
// write channel: reg_address, reg_data, last_write with write_valid and
// write_stall. Each sample gives a scan-limit write, then one write per
// digit, least significant first; last_write marks the final one.
// Before the scan-limit write a sample passes d times-ten steps (d = decimal
// places, at most 4), the one-bit-per-cycle divider, the serial BCD
// converter and the control states. The writes then follow one per cycle
// while the receiver does not stall.
// A stalled write holds its fields and the sequence simply waits.
// decimal_places sits at byte address 0 of the APB port; reset sets it to 3.
// Reset returns the block to idle with no write pending.
module temp_to_led_digit_writes #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [tld_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [tld_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [tld_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                  pready,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic signed [tld_pkg::RAW_W-1:0]      raw_sample,
	output logic                                  write_valid,
	input  logic                                  write_stall,
	output logic [tld_pkg::ADDR_W-1:0]            reg_address,
	output logic [tld_pkg::DATA_W-1:0]            reg_data,
	output logic                                  last_write
);
	import tld_pkg::*;

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int BCD_W = MAX_DIGITS * DIGIT_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCALE = 2'd1;
	localparam logic [1:0] S_BCD   = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0]          state_q;
	logic [DEC_W-1:0]    dp_q;
	logic [DEC_W-1:0]    dec_q;
	logic [BCD_W-1:0]    digits_q;
	logic [IDX_W-1:0]    dig_idx_q;
	logic [CNT_W-1:0]    count_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [DATA_W-1:0]   data_q;
	logic                last_q;

	logic                cfg_wr;
	logic                sample_acc;
	logic                write_acc;
	logic [DEC_W-1:0]    dec_clamped;
	tld_scale_res_t      scl_res;
	logic                bcd_done;
	logic [BCD_W-1:0]    bcd;
	logic [IDX_W-1:0]    hi_dig;
	logic [CNT_W-1:0]    count;
	logic                dot;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_DECIMAL_PLACES);
	assign prdata = (paddr == REG_DECIMAL_PLACES) ? CFG_DATA_W'(dp_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q <= DEC_RESET;
		end else if (cfg_wr) begin
			dp_q <= pwdata[DEC_W-1:0];
		end
	end

	assign sample_stall = state_q != S_IDLE;
	assign sample_acc   = sample_valid && !sample_stall;
	assign write_valid  = state_q == S_EMIT;
	assign write_acc    = write_valid && !write_stall;
	assign dec_clamped  = (dp_q > DEC_MAX) ? DEC_MAX : dp_q;

	tld_scale #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sample_acc),
		.raw    (raw_sample),
		.dec    (dec_clamped),
		.res    (scl_res)
	);

	tld_bcd #(
		.NDIG(MAX_DIGITS)
	) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scl_res.done),
		.value  (scl_res.value),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	always_comb begin
		hi_dig = '0;
		for (int k = 0; k < MAX_DIGITS; k++) begin
			if (bcd[k*DIGIT_W +: DIGIT_W] != 4'd0) hi_dig = IDX_W'(k);
		end
		count = CNT_W'(hi_dig) + 1'b1;
		dot   = 4'(dig_idx_q) == 4'(dec_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (sample_acc) state_q <= S_SCALE;
				S_SCALE: if (scl_res.done) state_q <= S_BCD;
				S_BCD:   if (bcd_done) state_q <= S_EMIT;
				S_EMIT:  if (write_acc && last_q) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) dec_q <= dec_clamped;
		if (state_q == S_BCD && bcd_done) begin
			digits_q  <= bcd;
			count_q   <= count;
			dig_idx_q <= '0;
			addr_q    <= SCAN_LIMIT_REG;
			data_q    <= DATA_W'(count - 1'b1);
			last_q    <= 1'b0;
		end else if (write_acc && !last_q) begin
			addr_q    <= 4'(dig_idx_q) + 4'd1;
			data_q    <= {dot, 3'b000, digits_q[DIGIT_W-1:0]};
			last_q    <= (CNT_W'(dig_idx_q) + 1'b1) == count_q;
			digits_q  <= digits_q >> DIGIT_W;
			dig_idx_q <= dig_idx_q + 1'b1;
		end
	end

	assign reg_address = addr_q;
	assign reg_data    = data_q;
	assign last_write  = last_q;

	a_first_is_scan_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(write_valid) |-> reg_address == SCAN_LIMIT_REG)
		else $error("first write of a sample is not the scan limit");

	a_last_ends_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		(write_acc && last_write) |=> !write_valid && !sample_stall)
		else $error("writes continue after the last transaction");

	a_digit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(write_valid && reg_address != SCAN_LIMIT_REG) |->
			reg_data[3:0] <= 4'd9 && reg_address >= 4'd1 && 32'(reg_address) <= MAX_DIGITS)
		else $error("digit write out of range");

	a_no_sample_while_writing: assert property (@(posedge clk) disable iff (!arst_n)
		write_valid |-> sample_stall)
		else $error("sample accepted while writes pending");

endmodule

### tb/temp_to_led_digit_writes_tb.sv
// Testbench for temp_to_led_digit_writes: scoreboard of predicted display register writes.
`timescale 1ns / 1ps

module temp_to_led_digit_writes_tb;
	import tld_pkg::*;

	localparam int                  HOLD_CYCLES   = 600;
	localparam int                  QUIET_LIMIT   = 4000;
	localparam int                  DIGITS_MAX    = 8;
	localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SPARE = 3'd4;

	class digit_write_board;
		typedef struct {
			logic [ADDR_W-1:0] addr;
			logic [DATA_W-1:0] data;
			logic              last;
		} reg_write_t;

		reg_write_t       pending[$];
		logic [DEC_W-1:0] dec_places;
		int               errors;

		function new();
			dec_places = DEC_RESET;
			errors     = 0;
		endfunction

		function void note_sample(logic signed [RAW_W-1:0] raw);
			longint     scale;
			longint     scaled;
			longint     value;
			longint     rest;
			int         shown;
			int         count;
			reg_write_t w;
			shown = (dec_places > DEC_MAX) ? int'(DEC_MAX) : int'(dec_places);
			scale = 1;
			for (int k = 0; k < shown; k++) begin
				scale = scale * 10;
			end
			scaled = (longint'(raw) * 100 + 64'sd1242020) * scale;
			value  = (scaled < 0) ? 0 : scaled / 34000;
			if (value > pow10(DIGITS_MAX) - 1) begin
				value = pow10(DIGITS_MAX) - 1;
			end
			count = 1;
			rest  = value;
			while (rest >= 10) begin
				count++;
				rest = rest / 10;
			end
			w.addr = SCAN_LIMIT_REG;
			w.data = DATA_W'(count - 1);
			w.last = 1'b0;
			pending.push_back(w);
			for (int i = 0; i < count; i++) begin
				w.addr = ADDR_W'(i + 1);
				w.data = DATA_W'(value % 10);
				if (i == shown) begin
					w.data = w.data | 8'h80;
				end
				w.last = (i == count - 1);
				pending.push_back(w);
				value = value / 10;
			end
		endfunction

		function void check_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
				logic last);
			reg_write_t w;
			if (pending.size() == 0) begin
				$error("unexpected write: reg_address %0d reg_data %0h last_write %0b",
					addr, data, last);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (addr !== w.addr) begin
				$error("reg_address: expected %0d, actual %0d", w.addr, addr);
				errors++;
			end
			if (data !== w.data) begin
				$error("reg_data: expected %0h, actual %0h", w.data, data);
				errors++;
			end
			if (last !== w.last) begin
				$error("last_write: expected %0b, actual %0b", w.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    psel         = 1'b0;
	logic                    penable      = 1'b0;
	logic                    pwrite       = 1'b0;
	logic [CFG_ADDR_W-1:0]   paddr        = '0;
	logic [CFG_DATA_W-1:0]   pwdata       = '0;
	logic [CFG_DATA_W-1:0]   prdata;
	logic                    pready;
	logic                    sample_valid = 1'b0;
	logic                    sample_stall;
	logic signed [RAW_W-1:0] raw_sample   = '0;
	logic                    write_valid;
	logic                    write_stall  = 1'b0;
	logic [ADDR_W-1:0]       reg_address;
	logic [DATA_W-1:0]       reg_data;
	logic                    last_write;

	digit_write_board board;
	bit               tx_idle   = 1'b0;
	bit               rx_idle   = 1'b0;
	bit               hold_req  = 1'b0;
	int               quiet     = 0;
	logic [DEC_W-1:0] phase_dec[10] = '{3'd1, 3'd2, 3'd0, 3'd4, 3'd3, 3'd6, 3'd7, 3'd5,
		3'd4, 3'd0};

	temp_to_led_digit_writes u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.raw_sample   (raw_sample),
		.write_valid  (write_valid),
		.write_stall  (write_stall),
		.reg_address  (reg_address),
		.reg_data     (reg_data),
		.last_write   (last_write)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && write_valid && !write_stall) begin
			board.check_write(reg_address, reg_data, last_write);
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (write_valid && !write_stall)) begin
			quiet = 0;
		end else begin
			quiet = quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("temp_to_led_digit_writes: mismatch");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		forever begin
			if (hold_req) begin
				write_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				write_stall <= 1'b0;
				hold_req = 1'b0;
				@(posedge clk);
			end else if (rx_idle && $urandom_range(0, 2) == 0) begin
				write_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				write_stall <= 1'b0;
				@(posedge clk);
			end else begin
				write_stall <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task automatic send_sample(input logic signed [RAW_W-1:0] raw);
		sample_valid <= 1'b1;
		raw_sample   <= raw;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		board.note_sample(raw);
		if (tx_idle && $urandom_range(0, 2) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [DEC_W-1:0] val);
		logic [CFG_DATA_W-1:0] word;
		word          = $urandom();
		word[DEC_W-1:0] = val;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == REG_DECIMAL_PLACES) begin
			board.dec_places = val;
		end
	endtask

	function automatic logic signed [RAW_W-1:0] pick_raw();
		int v;
		case ($urandom_range(0, 5))
			0, 1: v = int'($urandom_range(0, 65535)) - 32768;
			2: v = int'($urandom_range(0, 400)) - 12620;
			3: v = ($urandom_range(0, 1) != 0) ? 32767 - int'($urandom_range(0, 60))
				: -32768 + int'($urandom_range(0, 60));
			default: v = int'($urandom_range(0, 2000)) - 1000;
		endcase
		return v[RAW_W-1:0];
	endfunction

	initial begin
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: three decimals; clamp, zero value, dot past the digits
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		send_sample(16'sd0);
		send_sample(-16'sd1);
		send_sample(-16'sd12420);
		send_sample(-16'sd12421);
		send_sample(-16'sd12419);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		drain();
		apb_write(REG_DECIMAL_PLACES, 3'd0);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(-16'sd12419);
		send_sample(16'sd100);
		drain();
		apb_write(REG_DECIMAL_PLACES, 3'd4);
		send_sample(16'sd32767);
		send_sample(16'sd0);
		send_sample(-16'sd12420);
		drain();
		// settings above four behave as four
		apb_write(REG_DECIMAL_PLACES, 3'd7);
		send_sample(16'sd32767);
		send_sample(16'sd1000);
		drain();
		apb_write(REG_DECIMAL_PLACES, 3'd5);
		send_sample(-16'sd3);
		drain();
		// no register behind this address
		apb_write(CFG_ADDR_SPARE, 3'd0);
		send_sample(16'sd500);
		send_sample(16'sd20000);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			tx_idle = (ph < 8);
			rx_idle = (ph < 8);
			apb_write(REG_DECIMAL_PLACES, phase_dec[ph]);
			if (ph == 2) begin
				hold_req = 1'b1;
				for (int n = 0; n < 6; n++) begin
					send_sample(pick_raw());
				end
			end
			for (int n = 0; n < 34; n++) begin
				send_sample(pick_raw());
			end
			drain();
		end

		repeat (150) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("temp_to_led_digit_writes: match");
		end else begin
			$display("temp_to_led_digit_writes: mismatch");
		end
		$finish;
	end

endmodule
